// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the LED chain serializer.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clock, rst_n, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/rlcs_pkg.sv -----
// Types, codes and the color palette of the LED chain serializer.
// No dependencies; imported by the serializer top level.
package rlcs_pkg;

	// Command codes of the request stream.
	localparam logic [2:0] CMD_TICK    = 3'd0;
	localparam logic [2:0] CMD_SET_RGB = 3'd1;
	localparam logic [2:0] CMD_SET_PAL = 3'd2;
	localparam logic [2:0] CMD_FILL    = 3'd3;
	localparam logic [2:0] CMD_REFRESH = 3'd4;

	// Configuration register indexes.
	localparam logic [2:0] REG_PERIOD     = 3'd0;
	localparam logic [2:0] REG_DUTY_SET   = 3'd1;
	localparam logic [2:0] REG_DUTY_CLEAR = 3'd2;
	localparam logic [2:0] REG_LATCH_GAP  = 3'd3;
	localparam logic [2:0] REG_ACTIVE     = 3'd4;

	localparam int unsigned BITS_PER_LED = 24;
	localparam logic [4:0] LAST_BIT = 5'(BITS_PER_LED - 1);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SEND,
		PH_GAP
	} phase_t;

	// Colors are packed green in the top byte, then red, then blue.
	typedef logic [23:0] grb_t;

	function automatic grb_t palette_color(input logic [3:0] idx);
		grb_t c;
		begin
			case (idx)
				4'd0:    c = 24'h000000; // black
				4'd1:    c = 24'h404040; // white
				4'd2:    c = 24'h004000; // red
				4'd3:    c = 24'h400000; // green
				4'd4:    c = 24'h000040; // blue
				4'd5:    c = 24'h404000; // yellow
				4'd6:    c = 24'h400040; // cyan
				4'd7:    c = 24'h004040; // magenta
				4'd8:    c = 24'h204000; // orange
				4'd9:    c = 24'h002040; // purple
				4'd10:   c = 24'h1A402D; // pink
				default: c = 24'h000000; // indices past the palette read as black
			endcase
			return c;
		end
	endfunction

endpackage

// ----- hdl/rgb_led_chain_serializer.sv -----
// Top level of the one-wire RGB LED chain serializer: command decode, frame buffer,
// waveform counters and result register. Depends on rlcs_pkg, rlcs_ram and
// assert_macros.svh.
//
//   channel  | direction | content
//   ---------+-----------+----------------------------------------------------------
//   s_t*     | in        | requests: cmd, led, red, green, blue, color
//   m_t*     | out       | results: line, busy_res, accepted (one per request)
//   cfg_*    | in        | register writes: period, duties, latch gap, active level
//
// The whole update of a request happens in the cycle it is accepted
// and its result sits in the output register on the next cycle.
// A request is taken in every cycle in which the output register is empty or drained.
// A stall on the result side holds the result and stops requests; nothing is lost.
// Reset is asynchronous and needs no clearing pass: per-entry valid bits and a fill
// color stand in for clearing the frame buffer, so the block works from the first edge.
`include "assert_macros.svh"

module rgb_led_chain_serializer
	import rlcs_pkg::*;
#(
	parameter int LED_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel.
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: cmd[2:0], led[6:3], red[14:7], green[22:15], blue[30:23],
	// color[34:31], zero fill [39:35]
	input  logic [39:0] s_tdata,
	// Result channel.
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: line[0], busy_res[1], accepted[2], zero fill [7:3]
	output logic [7:0]  m_tdata,
	// Configuration write port.
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam logic [AW-1:0] LED_LAST = AW'(LED_COUNT - 1);
	localparam logic [8:0] LED_LIMIT = 9'(LED_COUNT);

	// Request fields.
	logic [2:0] cmd;
	logic [3:0] led;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [3:0] color;

	assign cmd   = s_tdata[2:0];
	assign led   = s_tdata[6:3];
	assign red   = s_tdata[14:7];
	assign green = s_tdata[22:15];
	assign blue  = s_tdata[30:23];
	assign color = s_tdata[34:31];

	// Configuration registers.
	logic [5:0]  period_q;
	logic [5:0]  duty_set_q;
	logic [5:0]  duty_clr_q;
	logic [11:0] gap_len_q;
	logic        act_q;

	// Waveform state.
	phase_t      phase_q, phase_d;
	logic [AW-1:0] led_cnt_q, led_cnt_d;
	logic [4:0]  bit_cnt_q, bit_cnt_d;
	logic [5:0]  tick_cnt_q, tick_cnt_d;
	logic [11:0] gap_cnt_q, gap_cnt_d;
	logic        held_q, held_d;

	// Frame buffer: a RAM plus per-entry valid bits; an entry not written since the
	// last fill (or reset) reads as the fill color.
	logic [LED_COUNT-1:0] vld_q;
	grb_t        fill_q;
	logic        fill_en;
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	grb_t        wr_data;
	grb_t        ram_rd;
	logic        byp_q;
	grb_t        byp_data_q;
	grb_t        word;
	logic        bit_val;
	logic [5:0]  duty;
	logic        led_in_range;

	// Result register.
	logic        out_valid_q;
	logic        res_line_q;
	logic        res_busy_q;
	logic        res_acc_q;
	logic        res_line_d;
	logic        res_acc_d;

	logic        acc;
	logic        inact;
	logic [6:0]  tick_inc;
	logic [12:0] gap_inc;

	// The output register parts the two sides: a new request enters whenever the
	// held result leaves in the same cycle or there is none.
	assign s_tready = !out_valid_q || m_tready;
	assign acc      = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, res_acc_q, res_busy_q, res_line_q};

	assign inact = ~act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= 6'd20;
			duty_set_q <= 6'd6;
			duty_clr_q <= 6'd13;
			gap_len_q  <= 12'd1600;
			act_q      <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PERIOD:     period_q   <= cfg_data[5:0];
				REG_DUTY_SET:   duty_set_q <= cfg_data[5:0];
				REG_DUTY_CLEAR: duty_clr_q <= cfg_data[5:0];
				REG_LATCH_GAP:  gap_len_q  <= cfg_data;
				REG_ACTIVE:     act_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The RAM read port follows the next LED counter, so during a refresh the word of
	// the current LED has already been read and is ready. A write that lands on the
	// address being read is forwarded for one cycle.
	rlcs_ram #(
		.WIDTH($bits(grb_t)),
		.DEPTH(LED_COUNT),
		.AW   (AW)
	) u_frame (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(led_cnt_d),
		.rd_data(ram_rd)
	);

	always_comb begin
		if (!vld_q[led_cnt_q]) begin
			word = fill_q;
		end else if (byp_q) begin
			word = byp_data_q;
		end else begin
			word = ram_rd;
		end
	end

	// Colors go out green first, most significant bit first.
	assign bit_val = word[LAST_BIT - bit_cnt_q];
	assign duty    = bit_val ? duty_set_q : duty_clr_q;

	assign led_in_range = ({5'd0, led} < LED_LIMIT);
	assign wr_addr      = AW'({28'd0, led});
	assign wr_data      = (cmd == CMD_SET_RGB) ? {green, red, blue} : palette_color(color);

	assign tick_inc = {1'b0, tick_cnt_q} + 7'd1;
	assign gap_inc  = {1'b0, gap_cnt_q} + 13'd1;

	always_comb begin
		phase_d    = phase_q;
		led_cnt_d  = led_cnt_q;
		bit_cnt_d  = bit_cnt_q;
		tick_cnt_d = tick_cnt_q;
		gap_cnt_d  = gap_cnt_q;
		held_d     = held_q;
		wr_en      = 1'b0;
		fill_en    = 1'b0;
		res_acc_d  = 1'b1;
		if (acc) begin
			if (cmd == CMD_TICK) begin
				case (phase_q)
					PH_SEND: begin
						held_d = (tick_cnt_q < duty) ? act_q : inact;
						// A period of zero or one ends the bit on every tick.
						if (tick_inc >= {1'b0, period_q}) begin
							tick_cnt_d = 6'd0;
							if (bit_cnt_q == LAST_BIT) begin
								bit_cnt_d = 5'd0;
								if (led_cnt_q == LED_LAST) begin
									led_cnt_d = '0;
									gap_cnt_d = 12'd0;
									phase_d   = (gap_len_q == 12'd0) ? PH_IDLE : PH_GAP;
								end else begin
									led_cnt_d = led_cnt_q + AW'(1);
								end
							end else begin
								bit_cnt_d = bit_cnt_q + 5'd1;
							end
						end else begin
							tick_cnt_d = tick_inc[5:0];
						end
					end
					PH_GAP: begin
						held_d = inact;
						if (gap_inc >= {1'b0, gap_len_q}) begin
							gap_cnt_d = 12'd0;
							phase_d   = PH_IDLE;
						end else begin
							gap_cnt_d = gap_inc[11:0];
						end
					end
					default: ;
				endcase
			end else if (phase_q != PH_IDLE) begin
				// Commands other than a tick are refused during a refresh and its latch gap.
				res_acc_d = 1'b0;
			end else begin
				if (cmd inside {CMD_SET_RGB, CMD_SET_PAL}) begin
					wr_en = led_in_range;
				end
				if (cmd == CMD_FILL) begin
					fill_en = 1'b1;
				end
				if (cmd inside {CMD_SET_PAL, CMD_FILL, CMD_REFRESH}) begin
					phase_d    = PH_SEND;
					led_cnt_d  = '0;
					bit_cnt_d  = 5'd0;
					tick_cnt_d = 6'd0;
					gap_cnt_d  = 12'd0;
					held_d     = inact;
				end
			end
		end
		// While idle a tick shows the held level; any other command shows the
		// inactive level.
		if (phase_d != PH_IDLE || cmd == CMD_TICK) begin
			res_line_d = held_d;
		end else begin
			res_line_d = inact;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			led_cnt_q  <= '0;
			bit_cnt_q  <= 5'd0;
			tick_cnt_q <= 6'd0;
			gap_cnt_q  <= 12'd0;
			held_q     <= 1'b0;
			vld_q      <= '0;
			fill_q     <= '0;
			byp_q      <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			led_cnt_q  <= led_cnt_d;
			bit_cnt_q  <= bit_cnt_d;
			tick_cnt_q <= tick_cnt_d;
			gap_cnt_q  <= gap_cnt_d;
			held_q     <= held_d;
			byp_q      <= wr_en && (wr_addr == led_cnt_d);
			if (fill_en) begin
				vld_q  <= '0;
				fill_q <= palette_color(color);
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_line_q <= res_line_d;
			res_busy_q <= (phase_d != PH_IDLE);
			res_acc_q  <= res_acc_d;
		end
	end

	// Outside a refresh all waveform counters rest at zero.
	`ASSERT_ALWAYS(a_idle_counters_clear, clk, arst_n, phase_q != PH_IDLE || (led_cnt_q == '0 && bit_cnt_q == 5'd0 && tick_cnt_q == 6'd0 && gap_cnt_q == 12'd0), "waveform counters not clear while idle")
	// The bit counter never leaves one LED's word.
	`ASSERT_ALWAYS(a_bit_in_word, clk, arst_n, bit_cnt_q <= LAST_BIT, "bit counter past the last color bit")
	// The frame buffer is never written while a refresh is running.
	`ASSERT_ALWAYS(a_no_write_busy, clk, arst_n, !(wr_en || fill_en) || phase_q == PH_IDLE, "frame buffer written during refresh")
	// A command taken during a refresh comes back refused and busy.
	`ASSERT_NEXT(a_refused, clk, arst_n, acc && cmd != CMD_TICK && phase_q != PH_IDLE, m_tvalid && !m_tdata[2] && m_tdata[1], "command during refresh not refused")

endmodule

// ----- hdl/rlcs_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the LED frame buffer.
module rlcs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
